FILE: hdl/anc_pkg.sv
// ============================================================================
// anc_pkg
// Shared widths and the command and status bundles that pass between the
// controller and the datapath of the amicable number checker.
// ============================================================================
package anc_pkg;

    // operand width: the input number and every trial value
    localparam int NUM_BITS = 32;
    // width of a running divisor sum and of the partner result
    localparam int ACC_W = 36;
    // step counter width of the serial divider
    localparam int CNT_W = $clog2(NUM_BITS);

    // commands from controller to datapath
    typedef struct packed {
        logic load_number;   // capture the request's number as the pass operand
        logic load_partner;  // use the first sum as the operand of pass two
        logic init_pass;     // first trial divisor and starting sum
        logic div_start;     // launch one division operand / trial divisor
        logic step;          // add divisor pair if it divides, advance divisor
        logic save_first;    // keep the first pass sum as the partner
    } anc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic operand_lt2;   // operand is 0 or 1
        logic div_done;      // quotient and remainder are valid
        logic quot_lt_div;   // quotient below trial divisor: scan is over
        logic first_ovf;     // partner does not fit the input range
        logic first_eq_n;    // partner equals the number (perfect or zero)
        logic acc_eq_n;      // second pass sum equals the number
    } anc_status_t;

endpackage

FILE: hdl/anc_divider.sv
// ============================================================================
// anc_divider
// Restoring serial divider: one quotient bit per cycle, with a one-cycle done
// pulse when quotient and remainder are valid.
// ============================================================================
module anc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [anc_pkg::NUM_BITS-1:0]  dividend,
    input  logic [anc_pkg::NUM_BITS-1:0]  divisor,
    output logic                          done,
    output logic [anc_pkg::NUM_BITS-1:0]  quotient,
    output logic [anc_pkg::NUM_BITS-1:0]  remainder
);

    localparam int W = anc_pkg::NUM_BITS;
    localparam int CW = anc_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quot_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // one restoring step: shift in the next dividend bit and try to subtract
    always_comb
    begin
        trial = {rem_reg, quot_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // control: run flag, step count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[W-2:0], fits};
            rem_reg  <= fits ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/anc_datapath.sv
// ============================================================================
// anc_datapath
// Operand, trial divisor and divisor sum registers around the serial divider;
// scans divisor pairs up to the square root of the pass operand.
// ============================================================================
module anc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [anc_pkg::NUM_BITS-1:0]  number,
    input  anc_pkg::anc_cmd_t             cmd,
    output anc_pkg::anc_status_t          status,
    output logic [anc_pkg::ACC_W-1:0]     partner
);

    localparam int W = anc_pkg::NUM_BITS;
    localparam int AW = anc_pkg::ACC_W;

    logic [W-1:0]  number_reg;
    logic [W-1:0]  operand_reg;
    logic [W-1:0]  trial_div_reg;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] first_sum_reg;

    logic [W-1:0]  quot;
    logic [W-1:0]  rem;
    logic          div_done;
    logic [AW-1:0] acc_next;

    anc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (operand_reg),
        .divisor   (trial_div_reg),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    // add the divisor and its cofactor, the cofactor only once at the root
    always_comb
    begin
        acc_next = acc_reg + AW'(trial_div_reg)
                 + ((quot != trial_div_reg) ? AW'(quot) : '0);
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_reg    <= '0;
            operand_reg   <= '0;
            trial_div_reg <= '0;
            acc_reg       <= '0;
            first_sum_reg <= '0;
        end
        else
        begin
            if (cmd.load_number)
            begin
                number_reg  <= number[W-1:0];
                operand_reg <= number[W-1:0];
            end
            else if (cmd.load_partner)
            begin
                operand_reg <= first_sum_reg[W-1:0];
            end

            if (cmd.init_pass)
            begin
                trial_div_reg <= W'(2);
                acc_reg       <= (operand_reg < W'(2)) ? '0 : AW'(1);
            end
            else if (cmd.step)
            begin
                trial_div_reg <= trial_div_reg + 1'b1;
                if (rem == '0)
                begin
                    acc_reg <= acc_next;
                end
            end

            if (cmd.save_first)
            begin
                first_sum_reg <= acc_reg;
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        status.operand_lt2 = (operand_reg < W'(2));
        status.div_done    = div_done;
        status.quot_lt_div = (quot < trial_div_reg);
        status.first_ovf   = (first_sum_reg[AW-1:W] != '0);
        status.first_eq_n  = (first_sum_reg == AW'(number_reg));
        status.acc_eq_n    = (acc_reg == AW'(number_reg));
    end

    assign partner = first_sum_reg;

endmodule

FILE: hdl/anc_ctrl.sv
// ============================================================================
// anc_ctrl
// Controller: sequences the two aliquot sum passes, decides whether the second
// pass runs, and raises the one-cycle done strobe with the result flags.
// ============================================================================
module anc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  anc_pkg::anc_status_t   status,
    output anc_pkg::anc_cmd_t      cmd,
    output logic                   busy,
    output logic                   done,
    output logic                   is_amicable,
    output logic                   overflow
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_PASS_END,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pass2_reg;
    logic   pass2_next;
    logic   done_reg;
    logic   done_next;
    logic   amic_reg;
    logic   amic_next;
    logic   ovf_reg;
    logic   ovf_next;

    // next state, commands and result flags
    always_comb
    begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        done_next  = 1'b0;
        amic_next  = amic_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_number = 1'b1;
                    pass2_next      = 1'b0;
                    state_next      = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_pass = 1'b1;
                state_next    = status.operand_lt2 ? ST_PASS_END : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.quot_lt_div)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_PASS_END:
            begin
                if (!pass2_reg)
                begin
                    cmd.save_first = 1'b1;
                    state_next     = ST_DECIDE;
                end
                else
                begin
                    done_next  = 1'b1;
                    amic_next  = status.acc_eq_n;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_DECIDE:
            begin
                // out of range or equal to the number: no second pass
                if (status.first_ovf || status.first_eq_n)
                begin
                    done_next  = 1'b1;
                    amic_next  = 1'b0;
                    ovf_next   = status.first_ovf;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.load_partner = 1'b1;
                    pass2_next       = 1'b1;
                    state_next       = ST_INIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass2_reg <= 1'b0;
            done_reg  <= 1'b0;
            amic_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
            done_reg  <= done_next;
            amic_reg  <= amic_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign is_amicable = amic_reg;
    assign overflow    = ovf_reg;

endmodule

FILE: hdl/amicable_number_checker.sv
// ============================================================================
// amicable_number_checker
// Each trial divisor takes one division in the serial divider loop, and a
// pass over operand v tries divisors from 2 until the quotient falls below
// the trial divisor; a request takes one or two passes.
// One request at a time; busy is high from acceptance until done.
// Reset: asynchronous, active low; returns to idle with done low.
// ============================================================================
module amicable_number_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   number,
    output logic                          busy,
    output logic                          done,
    output logic [anc_pkg::ACC_W-1:0]     partner,
    output logic                          is_amicable,
    output logic                          overflow
);

    anc_pkg::anc_cmd_t    cmd;
    anc_pkg::anc_status_t status;

    // sequencing of the two passes
    anc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .is_amicable (is_amicable),
        .overflow    (overflow)
    );

    // divisor scan and sums
    anc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .number  (number[anc_pkg::NUM_BITS-1:0]),
        .cmd     (cmd),
        .status  (status),
        .partner (partner)
    );

endmodule
